@@ src/wld_pkg.sv @@
// ----------------------------------------------------------------------------
// wld_pkg: shared types and constants of the local extremum detector
// Word layouts of the input and result channels, register widths and the
// flag pair that each window cell reports.
// ----------------------------------------------------------------------------
package wld_pkg;

    localparam int LOOKBACK_W = 5;
    localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 5'd2;

    localparam int SEEN_W = 24;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 24'hFF_FFFF;

    localparam int FIELD_PRICE_W = 32;

    typedef struct packed {
        logic                     series_start;
        logic [FIELD_PRICE_W-1:0] high_price;
        logic [FIELD_PRICE_W-1:0] low_price;
    } t_wld_in;

    typedef struct packed {
        logic [FIELD_PRICE_W-1:0] level_price;
        logic                     is_resistance;
        logic [SEEN_W-1:0]        candle_index;
        logic                     last;
    } t_wld_out;

    // Per-cell verdict against the centre candle
    typedef struct packed {
        logic above;   // neighbor high strictly above centre high
        logic below;   // neighbor low strictly below centre low
    } t_wld_flags;

endpackage

@@ src/window_local_extremum_detector_unit.sv @@
// ----------------------------------------------------------------------------
// window_local_extremum_detector_unit: swing high / swing low detector
// Shifts candles through a row of cells and reports the centre candle as a
// resistance and/or support level when no neighbor beats it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one candle per word,
//   high and low price plus a series_start flag that restarts the count.
//   Result channel (o_out_valid / i_out_ready / o_out): zero, one or two
//   words per candle, resistance before support, last set on the final one.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_lookback): always
//   ready; write only while the block is idle. 0 acts as 1, values above
//   MAX_LOOKBACK act as MAX_LOOKBACK.
// Timing:
//   A candle is taken in the idle state (window shift, centre capture) and
//   judged in the evaluate state after it, so no new candle is taken before
//   the last one is judged. The first result word is offered once the judge
//   cycle has loaded the result registers. The judge cycle waits while earlier
//   result words are still pending: a candle with two words delays the next
//   judge cycle even with a ready receiver, and a stalled receiver holds the
//   block after at most one further candle.
// Reset:
//   Clears the candle count, pending results and sets lookback to 2. Window
//   contents are not cleared; the candle count keeps stale entries unread.
// ----------------------------------------------------------------------------
module window_local_extremum_detector_unit #(
    parameter int MAX_LOOKBACK = 16,
    parameter int PRICE_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wld_pkg::t_wld_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wld_pkg::t_wld_out                   o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wld_pkg::LOOKBACK_W-1:0]      i_cfg_lookback
);

    localparam int DEPTH  = 2 * MAX_LOOKBACK + 1;
    localparam int SPAN_W = $clog2(MAX_LOOKBACK + 1);
    localparam int POS_W  = $clog2(DEPTH);
    localparam int FW     = wld_pkg::FIELD_PRICE_W;
    localparam int SW     = wld_pkg::SEEN_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [wld_pkg::LOOKBACK_W-1:0]  r_lookback;
    logic [SW-1:0]                   r_seen, n_seen;
    logic                            r_pend_r, n_pend_r;
    logic                            r_pend_s, n_pend_s;

    // Centre candle captured at acceptance, judged in the evaluate state
    logic [PRICE_WIDTH-1:0]          r_c_hi, r_c_lo;
    logic                            r_judge;
    logic [SW-1:0]                   r_cidx;

    // Result word holding registers
    logic [PRICE_WIDTH-1:0]          r_o_hi, r_o_lo;
    logic [SW-1:0]                   r_o_idx;

    logic [SPAN_W-1:0]               w_span;
    logic [POS_W-1:0]                w_cpos;
    logic [PRICE_WIDTH+FW-1:0]       w_ext_hi, w_ext_lo;
    logic [PRICE_WIDTH-1:0]          w_in_hi, w_in_lo;
    logic [PRICE_WIDTH-1:0]          w_hi [DEPTH];
    logic [PRICE_WIDTH-1:0]          w_lo [DEPTH];
    wld_pkg::t_wld_flags             w_flags [DEPTH];
    logic [DEPTH-1:0]                w_above, w_below;
    logic                            w_in_acc, w_out_acc, w_load;
    logic [SW-1:0]                   w_seen_nx, w_thr;
    logic [PRICE_WIDTH+FW-1:0]       w_sel_ext;

    // Fit the price fields to the internal price width
    assign w_ext_hi = {PRICE_WIDTH'(0), i_in.high_price};
    assign w_ext_lo = {PRICE_WIDTH'(0), i_in.low_price};
    assign w_in_hi  = w_ext_hi[PRICE_WIDTH-1:0];
    assign w_in_lo  = w_ext_lo[PRICE_WIDTH-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_pend_r || r_pend_s;
    assign w_out_acc   = o_out_valid && i_out_ready;

    // Clamp lookback into the supported span
    always_comb begin
        if (r_lookback == '0) begin
            w_span = SPAN_W'(1);
        end else if (int'(r_lookback) > MAX_LOOKBACK) begin
            w_span = SPAN_W'(MAX_LOOKBACK);
        end else begin
            w_span = SPAN_W'(r_lookback);
        end
    end

    // Row of cells; cell 0 takes the incoming candle
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            wld_cell #(
                .PRICE_WIDTH (PRICE_WIDTH),
                .POS         (g),
                .SPAN_W      (SPAN_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_in_acc),
                .i_span  (w_span),
                .i_hi    ((g == 0) ? w_in_hi : w_hi[(g == 0) ? 0 : g - 1]),
                .i_lo    ((g == 0) ? w_in_lo : w_lo[(g == 0) ? 0 : g - 1]),
                .i_c_hi  (r_c_hi),
                .i_c_lo  (r_c_lo),
                .o_hi    (w_hi[g]),
                .o_lo    (w_lo[g]),
                .o_flags (w_flags[g])
            );
            assign w_above[g] = w_flags[g].above;
            assign w_below[g] = w_flags[g].below;
        end
    endgenerate

    // After the shift the centre sits at position span, i.e. span-1 now
    assign w_cpos = POS_W'(w_span) - POS_W'(1);

    always_comb begin
        if (i_in.series_start) begin
            w_seen_nx = SW'(1);
        end else if (r_seen == wld_pkg::SEEN_MAX) begin
            w_seen_nx = r_seen;
        end else begin
            w_seen_nx = r_seen + SW'(1);
        end
    end

    assign w_thr  = SW'({w_span, 1'b0}) + SW'(1);
    assign w_load = (r_state == S_EVAL) && !r_pend_r && !r_pend_s;

    // Control next-state
    always_comb begin
        n_state  = r_state;
        n_seen   = r_seen;
        n_pend_r = r_pend_r;
        n_pend_s = r_pend_s;
        if (w_out_acc) begin
            if (r_pend_r) begin
                n_pend_r = 1'b0;
            end else begin
                n_pend_s = 1'b0;
            end
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_seen  = w_seen_nx;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // Hold until earlier result words are gone
                if (w_load) begin
                    n_pend_r = r_judge && !(|w_above);
                    n_pend_s = r_judge && !(|w_below);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seen     <= '0;
            r_pend_r   <= 1'b0;
            r_pend_s   <= 1'b0;
            r_lookback <= wld_pkg::LOOKBACK_RESET;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_pend_r <= n_pend_r;
            r_pend_s <= n_pend_s;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lookback <= i_cfg_lookback;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_c_hi  <= w_hi[w_cpos];
            r_c_lo  <= w_lo[w_cpos];
            r_judge <= (w_seen_nx >= w_thr);
            r_cidx  <= w_seen_nx - SW'(1) - SW'(w_span);
        end
        if (w_load) begin
            r_o_hi  <= r_c_hi;
            r_o_lo  <= r_c_lo;
            r_o_idx <= r_cidx;
        end
    end

    // Resistance goes first; support, when present, is the closing word
    assign w_sel_ext = {FW'(0), (r_pend_r ? r_o_hi : r_o_lo)};

    assign o_out.level_price   = w_sel_ext[FW-1:0];
    assign o_out.is_resistance = r_pend_r;
    assign o_out.candle_index  = r_o_idx;
    assign o_out.last          = !(r_pend_r && r_pend_s);

endmodule

@@ src/wld_cell.sv @@
// ----------------------------------------------------------------------------
// wld_cell: one window position
// Holds one candle, hands it to the next cell on every shift and compares
// it against the broadcast centre candle.
// ----------------------------------------------------------------------------
module wld_cell #(
    parameter int PRICE_WIDTH = 32,
    parameter int POS         = 0,
    parameter int SPAN_W      = 5
) (
    input  logic                    i_clk,
    input  logic                    i_shift,
    input  logic [SPAN_W-1:0]       i_span,
    input  logic [PRICE_WIDTH-1:0]  i_hi,
    input  logic [PRICE_WIDTH-1:0]  i_lo,
    input  logic [PRICE_WIDTH-1:0]  i_c_hi,
    input  logic [PRICE_WIDTH-1:0]  i_c_lo,
    output logic [PRICE_WIDTH-1:0]  o_hi,
    output logic [PRICE_WIDTH-1:0]  o_lo,
    output wld_pkg::t_wld_flags     o_flags
);

    logic [PRICE_WIDTH-1:0] r_hi;
    logic [PRICE_WIDTH-1:0] r_lo;
    logic                   w_en;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hi <= i_hi;
            r_lo <= i_lo;
        end
    end

    // Take part only inside the span, never as the centre itself
    assign w_en = (POS <= 2 * int'(i_span)) && (POS != int'(i_span));

    assign o_hi          = r_hi;
    assign o_lo          = r_lo;
    assign o_flags.above = w_en && (r_hi > i_c_hi);
    assign o_flags.below = w_en && (r_lo < i_c_lo);

endmodule

@@ src/wld_checker.sv @@
// ----------------------------------------------------------------------------
// wld_checker: port-level checks of the extremum detector
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module wld_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input wld_pkg::t_wld_out o_out
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result word changed while stalled");

    // Only a resistance word can be followed by a second word
    a_not_last_is_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> o_out.is_resistance)
        else $error("non-final word is not a resistance level");

    // After a non-final word the support word follows at once
    a_support_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last)
            |=> (o_out_valid && !o_out.is_resistance && o_out.last))
        else $error("support word missing after resistance");

    // An accepted candle is judged before the next one is taken
    a_judge_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken during judge cycle");

endmodule

bind window_local_extremum_detector_unit wld_checker u_wld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

@@ test/tb_window_local_extremum_detector_unit.sv @@
// ----------------------------------------------------------------------------
// tb_window_local_extremum_detector_unit: self-checking bench for the swing
// high / swing low detector
// Streams candles through the input channel, predicts every resistance and
// support word from a private copy of the candle window, and compares each
// result word field by field against the oldest prediction. Directed cases
// cover ties, price extremes, series restart and lookback changes; random
// phases sweep the lookback register with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_window_local_extremum_detector_unit;

    localparam int LOOKBACK_W    = wld_pkg::LOOKBACK_W;
    localparam int SEEN_W        = wld_pkg::SEEN_W;
    localparam int FIELD_PRICE_W = wld_pkg::FIELD_PRICE_W;

    localparam int MAX_LB      = 16;
    localparam int WIN_DEPTH   = 2 * MAX_LB + 1;
    localparam int SETTLE_CYC  = 6;        // covers the take + judge cycles
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam logic [FIELD_PRICE_W-1:0] PRICE_TOP = '1;

    // Price shapes for generated candles
    typedef enum int {
        PRICE_FULL,     // any 32-bit value
        PRICE_NEAR,     // zero to three steps above a shared base, makes ties likely
        PRICE_ZERO,
        PRICE_CEIL
    } t_price_shape;

    // ------------------------------------------------------------------------
    // DUT signals: every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    wld_pkg::t_wld_in      i_in           = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    wld_pkg::t_wld_out     o_out;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [LOOKBACK_W-1:0] i_cfg_lookback = '0;

    window_local_extremum_detector_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_lookback (i_cfg_lookback)
    );

    // ------------------------------------------------------------------------
    // Predictor state: candle window (entry 0 newest), series count, lookback
    // ------------------------------------------------------------------------
    logic [FIELD_PRICE_W-1:0] hist_hi [WIN_DEPTH];
    logic [FIELD_PRICE_W-1:0] hist_lo [WIN_DEPTH];
    logic [SEEN_W-1:0]        series_count = '0;
    logic [LOOKBACK_W-1:0]    lookback_reg = wld_pkg::LOOKBACK_RESET;

    wld_pkg::t_wld_out        levels_due[$];     // predicted level words, oldest first
    int                       fault_count = 0;
    int                       cycle_count = 0;
    bit                       idle_on     = 1'b1;
    int                       stall_left  = 0;
    logic [FIELD_PRICE_W-1:0] tie_base    = '0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // End the run if the block hangs anywhere
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d level words still due",
                     cycle_count, levels_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: while idling is on, drop ready for random runs of cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(1, 18) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0d] %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        wld_pkg::t_wld_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (levels_due.size() == 0) begin
                log_fault($sformatf("unexpected word: price %h res %b idx %0d last %b",
                                    o_out.level_price, o_out.is_resistance,
                                    o_out.candle_index, o_out.last));
            end else begin
                want = levels_due.pop_front();
                if (o_out.level_price   !== want.level_price   ||
                    o_out.is_resistance !== want.is_resistance ||
                    o_out.candle_index  !== want.candle_index  ||
                    o_out.last          !== want.last) begin
                    log_fault($sformatf({"mismatch: exp price %h res %b idx %0d last %b,",
                                         " got price %h res %b idx %0d last %b"},
                                        want.level_price, want.is_resistance,
                                        want.candle_index, want.last,
                                        o_out.level_price, o_out.is_resistance,
                                        o_out.candle_index, o_out.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: shift one candle in and judge the centre of the window
    // ------------------------------------------------------------------------
    task automatic judge_candle(input wld_pkg::t_wld_in w);
        int unsigned              span;
        logic [FIELD_PRICE_W-1:0] mid_hi;
        logic [FIELD_PRICE_W-1:0] mid_lo;
        bit                       peak;
        bit                       trough;
        wld_pkg::t_wld_out        lv;
        if (w.series_start) begin
            foreach (hist_hi[k]) begin
                hist_hi[k] = '0;
                hist_lo[k] = '0;
            end
            series_count = '0;
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            hist_hi[k] = hist_hi[k-1];
            hist_lo[k] = hist_lo[k-1];
        end
        hist_hi[0] = w.high_price;
        hist_lo[0] = w.low_price;
        if (series_count != wld_pkg::SEEN_MAX)
            series_count++;

        // Clamp the register: 0 acts as 1, anything past MAX_LB as the max
        if (lookback_reg == 0)
            span = 1;
        else if (lookback_reg > MAX_LB)
            span = MAX_LB;
        else
            span = lookback_reg;

        // Hold off until the series fills the current span
        if (series_count < 2 * span + 1)
            return;

        mid_hi = hist_hi[span];
        mid_lo = hist_lo[span];
        peak   = 1'b1;
        trough = 1'b1;
        for (int unsigned k = 0; k <= 2 * span; k++) begin
            if (k != span) begin
                if (hist_hi[k] > mid_hi) peak   = 1'b0;
                if (hist_lo[k] < mid_lo) trough = 1'b0;
            end
        end

        lv.candle_index = series_count - SEEN_W'(1) - SEEN_W'(span);
        if (peak) begin
            lv.level_price   = mid_hi;
            lv.is_resistance = 1'b1;
            lv.last          = !trough;
            levels_due.push_back(lv);
        end
        if (trough) begin
            lv.level_price   = mid_lo;
            lv.is_resistance = 1'b0;
            lv.last          = 1'b1;
            levels_due.push_back(lv);
        end
    endtask

    // ------------------------------------------------------------------------
    // Channel helpers
    // ------------------------------------------------------------------------

    // Present one candle and hold it until accepted; valid stays high on return
    task automatic send_candle(input wld_pkg::t_wld_in w);
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        judge_candle(w);
    endtask

    task automatic send_hl(input bit ss, input logic [31:0] hi, input logic [31:0] lo);
        wld_pkg::t_wld_in w;
        w.series_start = ss;
        w.high_price   = hi;
        w.low_price    = lo;
        send_candle(w);
    endtask

    // Insert a random sender gap now and then
    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every predicted word, then let the judge cycle finish
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_lookback(input logic [LOOKBACK_W-1:0] v);
        settle_block();
        i_cfg_valid    <= 1'b1;
        i_cfg_lookback <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        lookback_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_PRICE_W-1:0] pick_price();
        t_price_shape shape;
        int           roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)       shape = PRICE_FULL;
        else if (roll < 8)  shape = PRICE_NEAR;
        else if (roll == 8) shape = PRICE_ZERO;
        else                shape = PRICE_CEIL;
        case (shape)
            PRICE_FULL: return $urandom;
            PRICE_NEAR: return tie_base + $urandom_range(0, 3);
            PRICE_ZERO: return '0;
            default:    return PRICE_TOP;
        endcase
    endfunction

    // One random phase: set lookback, then stream candles with rare restarts
    task automatic run_phase(input logic [LOOKBACK_W-1:0] lb, input int count);
        wld_pkg::t_wld_in w;
        write_lookback(lb);
        tie_base = $urandom;
        for (int i = 0; i < count; i++) begin
            w.series_start = (i == 0) ? 1'($urandom_range(0, 1))
                                      : ($urandom_range(0, 49) == 0);
            w.high_price   = pick_price();
            w.low_price    = pick_price();
            send_candle(w);
            maybe_gap();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test cases
    // ------------------------------------------------------------------------

    // Reset lookback of 2: tied flat candles at the price extremes, then two differing ones
    task automatic test_flat_extremes();
        send_hl(1'b1, PRICE_TOP, '0);
        repeat (4) send_hl(1'b0, PRICE_TOP, '0);
        send_hl(1'b0, 32'd10, 32'd20);
        send_hl(1'b0, '0, PRICE_TOP);
    endtask

    // Register value 0 acts as lookback 1: clear peak and trough
    task automatic test_lookback_floor();
        write_lookback('0);
        send_hl(1'b1, 32'd100, 32'd50);
        send_hl(1'b0, 32'd200, 32'd40);
        send_hl(1'b0, 32'd150, 32'd60);
        send_hl(1'b0, 32'd150, 32'd60);
        send_hl(1'b0, 32'd300, 32'd10);
    endtask

    // Restart mid-stream: index returns to 0 and judging waits for a new fill
    task automatic test_series_restart();
        write_lookback(5'd1);
        send_hl(1'b1, 32'd5, 32'd5);
        send_hl(1'b0, 32'd1, 32'd1);
        send_hl(1'b1, 32'd7, 32'd7);
        send_hl(1'b0, 32'd8, 32'd6);
        send_hl(1'b0, 32'd6, 32'd9);
    endtask

    // Widen lookback without a restart; the series must grow before judging resumes
    task automatic test_lookback_change_mid_series();
        send_hl(1'b0, 32'd4, 32'd4);
        send_hl(1'b0, 32'd9, 32'd2);
        write_lookback(5'd3);
        send_hl(1'b0, 32'd3, 32'd3);
        send_hl(1'b0, 32'd3, 32'd8);
        send_hl(1'b0, 32'd2, 32'd9);
    endtask

    // Sweep lookback through the clamped extremes and mid values
    task automatic test_random_lookbacks();
        run_phase(5'd16, 90);
        run_phase(5'd17, 60);
        run_phase(5'd31, 50);
        run_phase(5'd2, 60);
        run_phase(5'd1, 50);
        run_phase(5'd0, 50);
        run_phase(LOOKBACK_W'($urandom_range(0, 31)), 50);
        run_phase(5'd4, 50);
    endtask

    // Pause the sender until every predicted word has drained, then resume
    task automatic test_drain_pause();
        wld_pkg::t_wld_in w;
        write_lookback(5'd2);
        for (int i = 0; i < 40; i++) begin
            if (i == 20)
                settle_block();
            w.series_start = (i == 0);
            w.high_price   = pick_price();
            w.low_price    = pick_price();
            send_candle(w);
            maybe_gap();
        end
    endtask

    // Closing stretch with both sides running flat out
    task automatic test_full_rate();
        settle_block();
        idle_on = 1'b0;
        run_phase(LOOKBACK_W'($urandom_range(1, 6)), 60);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (hist_hi[k]) begin
            hist_hi[k] = '0;
            hist_lo[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flat_extremes();
        test_lookback_floor();
        test_series_restart();
        test_lookback_change_mid_series();
        test_random_lookbacks();
        test_drain_pause();
        test_full_rate();

        // Drain and give the block time to show any stray word
        settle_block();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && levels_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/wld_pkg.sv
src/wld_cell.sv
src/window_local_extremum_detector_unit.sv
src/wld_checker.sv
test/tb_window_local_extremum_detector_unit.sv
